### rtl/positional_list_store_core_macros.svh
// Assertion macros used by the positional list store top level.
`ifndef POSITIONAL_LIST_STORE_CORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_CORE_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define PLSC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/plsc_pkg.sv
// Package: sizes, codes and cell control type for the positional list store.
`default_nettype none
package plsc_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int POS_W     = 8;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [ACT_W-1:0] ACT_INS  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             ins;    // accepted insert that succeeds
    logic             del;    // accepted delete that succeeds
    logic             rd;     // read within range
    logic [CNT_W-1:0] at;     // target index, already clamped
    logic [CNT_W-1:0] count;  // current fill count
  } ctrl_t;

endpackage
`default_nettype wire

### rtl/plsc_cell.sv
// One storage cell of the list row: holds a word, shifts with its neighbors.
`default_nettype none
module plsc_cell (
  input  wire                            clk,
  input  wire  [plsc_pkg::IDX_W-1:0]     idx,
  input  plsc_pkg::ctrl_t                ctrl,
  input  wire  [plsc_pkg::WORD_BITS-1:0] word_in,
  input  wire  [plsc_pkg::WORD_BITS-1:0] left_in,
  input  wire  [plsc_pkg::WORD_BITS-1:0] right_in,
  output logic [plsc_pkg::WORD_BITS-1:0] q,
  output logic [plsc_pkg::WORD_BITS-1:0] rd_tap,
  output logic [plsc_pkg::WORD_BITS-1:0] last_tap
);
  import plsc_pkg::*;

  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] data_nxt;
  logic [CNT_W-1:0]     idx_e;
  logic [CNT_W-1:0]     idx_p1;

  assign idx_e  = CNT_W'(idx);
  assign idx_p1 = idx_e + CNT_W'(1);

  always_comb begin
    priority if (ctrl.ins && idx_e == ctrl.at) begin
      data_nxt = word_in;
    end else if (ctrl.ins && idx_e > ctrl.at && idx_e <= ctrl.count) begin
      data_nxt = left_in;
    end else if (ctrl.del && idx_e >= ctrl.at && idx_p1 < ctrl.count) begin
      data_nxt = right_in;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q        = data_r;
  assign rd_tap   = (ctrl.rd && idx_e == ctrl.at) ? data_r : '0;
  assign last_tap = (idx_p1 == ctrl.count) ? data_r : '0;

endmodule
`default_nettype wire

### rtl/positional_list_store_core.sv
// Top level: positional list store built from a shifting row of word cells.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------------
//   in      | input     | in_valid, in_ready, in_action, in_position, in_value_in
//   out     | output    | out_valid, out_ready, out_status, out_read_value,
//           |           | out_first_value, out_last_value, out_entry_count
//
// One item per cycle: an item is applied to the cell row in the cycle it is
// accepted; every cell loads, shifts from a neighbor or holds in that cycle.
// Its result is valid from the next cycle. A new item is taken while the
// result register is empty or is being emptied in the same cycle.
// Reset clears the fill count and the result valid; cell contents are left as is.
`default_nettype none
module positional_list_store_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [plsc_pkg::ACT_W-1:0]      in_action,
  input  wire  [plsc_pkg::POS_W-1:0]      in_position,
  input  wire  [plsc_pkg::WORD_BITS-1:0]  in_value_in,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [plsc_pkg::STAT_W-1:0]     out_status,
  output logic [plsc_pkg::WORD_BITS-1:0]  out_read_value,
  output logic [plsc_pkg::WORD_BITS-1:0]  out_first_value,
  output logic [plsc_pkg::WORD_BITS-1:0]  out_last_value,
  output logic [plsc_pkg::CNT_W-1:0]      out_entry_count
);
  import plsc_pkg::*;
  `include "positional_list_store_core_macros.svh"

  logic                 acc;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [STAT_W-1:0]    status_r;
  logic [STAT_W-1:0]    status_nxt;
  logic [WORD_BITS-1:0] rdval_r;
  logic [WORD_BITS-1:0] rdval_nxt;
  logic [CMP_W-1:0]     pos_e;
  logic [CMP_W-1:0]     cnt_e;
  logic                 pos_ge;
  logic                 is_full;
  logic                 is_empty;
  logic                 ins_ok;
  logic                 del_ok;
  logic                 rd_ok;
  ctrl_t                ctrl;
  logic [WORD_BITS-1:0] cell_q    [DEPTH];
  logic [WORD_BITS-1:0] rd_tap    [DEPTH];
  logic [WORD_BITS-1:0] last_tap  [DEPTH];
  logic [WORD_BITS-1:0] rd_any;
  logic [WORD_BITS-1:0] last_any;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  assign pos_e    = CMP_W'(in_position);
  assign cnt_e    = CMP_W'(count_r);
  assign pos_ge   = pos_e >= cnt_e;
  assign is_full  = count_r == CNT_W'(DEPTH);
  assign is_empty = count_r == '0;

  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    rd_ok      = 1'b0;
    status_nxt = ST_OK;
    unique case (in_action)
      ACT_INS: begin
        if (is_full) status_nxt = ST_FULL;
        else         ins_ok     = 1'b1;
      end
      ACT_DEL: begin
        if (is_empty) status_nxt = ST_EMPTY;
        else          del_ok     = 1'b1;
      end
      ACT_READ: begin
        if (pos_ge) status_nxt = ST_EMPTY;
        else        rd_ok      = 1'b1;
      end
      default: status_nxt = ST_EMPTY;
    endcase
  end

  always_comb begin
    ctrl.ins   = acc && ins_ok;
    ctrl.del   = acc && del_ok;
    ctrl.rd    = rd_ok;
    ctrl.count = count_r;
    priority if (!pos_ge)          ctrl.at = CNT_W'(pos_e);
    else if (in_action == ACT_DEL) ctrl.at = count_r - CNT_W'(1);
    else                           ctrl.at = count_r;
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] left_w;
      logic [WORD_BITS-1:0] right_w;
      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_q[g+1];
      end
      plsc_cell u_cell (
        .clk      (clk),
        .idx      (IDX_W'(g)),
        .ctrl     (ctrl),
        .word_in  (in_value_in),
        .left_in  (left_w),
        .right_in (right_w),
        .q        (cell_q[g]),
        .rd_tap   (rd_tap[g]),
        .last_tap (last_tap[g])
      );
    end
  endgenerate

  // at most one cell matches in each case, so an OR picks it out
  always_comb begin
    rd_any   = '0;
    last_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any   = rd_any | rd_tap[i];
      last_any = last_any | last_tap[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins)      count_nxt = count_r + CNT_W'(1);
    else if (ctrl.del) count_nxt = count_r - CNT_W'(1);
  end

  assign rdval_nxt = rd_any;

  always_comb begin
    priority if (acc)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
    end
  end

  // cells and count change only when a new item replaces the held result
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = rdval_r;
  assign out_first_value = is_empty ? '0 : cell_q[0];
  assign out_last_value  = last_any;
  assign out_entry_count = count_r;

  `PLSC_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "fill count above depth")
  `PLSC_ASSERT_NEXT(a_ins_count, ctrl.ins, count_r == $past(count_r) + CNT_W'(1), "insert count")
  `PLSC_ASSERT_NEXT(a_del_count, ctrl.del, count_r == $past(count_r) - CNT_W'(1), "delete count")
  `PLSC_ASSERT_ALWAYS(a_full_stat, !(out_valid_r && status_r == ST_FULL) || is_full, "full status")
  `PLSC_ASSERT_ALWAYS(a_rd_zero, !(out_valid_r && status_r != ST_OK) || rdval_r == '0, "read on error")

endmodule
`default_nettype wire

### tb/sv/positional_list_store_core_test.sv
// Testbench for the positional list store: queued stimulus, inline predictor, output checker.
`timescale 1ns / 1ps
module positional_list_store_core_test;
  import plsc_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_OPS  = 1400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 150;

  typedef struct {
    logic [ACT_W-1:0]     action;
    logic [POS_W-1:0]     position;
    logic [WORD_BITS-1:0] value;
  } list_op_t;

  typedef struct {
    logic [STAT_W-1:0]    status;
    logic [WORD_BITS-1:0] read_value;
    logic [WORD_BITS-1:0] first_value;
    logic [WORD_BITS-1:0] last_value;
    logic [CNT_W-1:0]     count;
  } list_view_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACT_W-1:0]     in_action = ACT_INS;
  logic [POS_W-1:0]     in_position = '0;
  logic [WORD_BITS-1:0] in_value_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [WORD_BITS-1:0] out_read_value;
  logic [WORD_BITS-1:0] out_first_value;
  logic [WORD_BITS-1:0] out_last_value;
  logic [CNT_W-1:0]     out_entry_count;

  positional_list_store_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_position     (in_position),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_first_value (out_first_value),
    .out_last_value  (out_last_value),
    .out_entry_count (out_entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted list contents
  logic [WORD_BITS-1:0] list_words [DEPTH];
  int                   list_len = 0;

  list_op_t   pending_ops [$];
  list_view_t expected_views [$];

  int errors = 0;
  int sent_ops = 0;
  int accepted_ops = 0;
  int results_checked = 0;
  int full_rejects = 0;
  int empty_rejects = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  list_op_t   next_op;
  list_view_t seen_view;

  function automatic list_view_t apply_op(list_op_t op);
    list_view_t v;
    int at;
    v.status = ST_OK;
    v.read_value = '0;
    case (op.action)
      ACT_INS: begin
        if (list_len >= DEPTH) begin
          v.status = ST_FULL;
          full_rejects++;
        end else begin
          at = (op.position >= list_len) ? list_len : op.position;
          for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = op.value;
          list_len++;
        end
      end
      ACT_DEL: begin
        if (list_len == 0) begin
          v.status = ST_EMPTY;
          empty_rejects++;
        end else begin
          // position past the end removes the tail word
          at = (op.position >= list_len) ? list_len - 1 : op.position;
          for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ACT_READ: begin
        if (op.position >= list_len) begin
          v.status = ST_EMPTY;
          empty_rejects++;
        end else begin
          v.read_value = list_words[op.position];
        end
      end
      default: begin
        v.status = ST_EMPTY;
      end
    endcase
    v.first_value = (list_len > 0) ? list_words[0] : '0;
    v.last_value  = (list_len > 0) ? list_words[list_len-1] : '0;
    v.count       = list_len[CNT_W-1:0];
    return v;
  endfunction

  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic check_field(string name, logic [WORD_BITS-1:0] exp_v,
                             logic [WORD_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver: presents queued items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        next_op.action   = in_action;
        next_op.position = in_position;
        next_op.value    = in_value_in;
        expected_views.push_back(apply_op(next_op));
        accepted_ops++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          in_valid    <= 1'b1;
          in_action   <= next_op.action;
          in_position <= next_op.position;
          in_value_in <= next_op.value;
          sent_ops++;
          send_gap = idle_len((sent_ops / 120) % 3 == 2);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction, drives out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("result with no item outstanding: status %0d count %0d",
                 out_status, out_entry_count);
          errors++;
        end else begin
          seen_view = expected_views.pop_front();
          check_field("status", WORD_BITS'(seen_view.status), WORD_BITS'(out_status));
          check_field("read_value", seen_view.read_value, out_read_value);
          check_field("first_value", seen_view.first_value, out_first_value);
          check_field("last_value", seen_view.last_value, out_last_value);
          check_field("entry_count", WORD_BITS'(seen_view.count),
                      WORD_BITS'(out_entry_count));
        end
        results_checked++;
        recv_stall = idle_len((cycles / 500) % 3 == 1);
      end
      // one long hold-off so the sender backs up against a full result stage
      if (!hold_done && results_checked >= 300) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycles,
               expected_views.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  int gen_len = 0;

  task automatic add_op(logic [ACT_W-1:0] action, logic [POS_W-1:0] position,
                        logic [WORD_BITS-1:0] value);
    list_op_t op;
    op.action   = action;
    op.position = position;
    op.value    = value;
    pending_ops.push_back(op);
    if (action == ACT_INS && gen_len < DEPTH) gen_len++;
    else if (action == ACT_DEL && gen_len > 0) gen_len--;
  endtask

  initial begin
    int mode;
    int mode_left;
    int r;
    logic [ACT_W-1:0]     act;
    logic [POS_W-1:0]     pos;
    logic [WORD_BITS-1:0] val;
    mode = 0;
    mode_left = 0;

    // empty list: rejected delete, rejected read, unused code
    add_op(ACT_DEL, 8'd0, '0);
    add_op(ACT_READ, 8'd0, '0);
    add_op(ACT_READ, 8'd255, '0);
    add_op(ACT_UNUSED, 8'd0, 32'hFFFF_FFFF);
    // front insert, appends past the end, middle insert, insert at count
    add_op(ACT_INS, 8'd0, 32'hFFFF_FFFF);
    add_op(ACT_INS, 8'd255, 32'h0000_0000);
    add_op(ACT_INS, 8'd1, 32'hA5A5_A5A5);
    add_op(ACT_INS, 8'd3, 32'h5A5A_5A5A);
    add_op(ACT_INS, 8'd200, 32'h1234_5678);
    add_op(ACT_READ, 8'd0, 32'hDEAD_BEEF);
    add_op(ACT_READ, 8'd4, '0);
    add_op(ACT_READ, 8'd5, '0);
    add_op(ACT_UNUSED, 8'd255, '0);
    // middle delete, tail delete past the end, tail delete at count-1, pop
    add_op(ACT_DEL, 8'd2, '0);
    add_op(ACT_DEL, 8'd255, '0);
    add_op(ACT_DEL, 8'd2, '0);
    add_op(ACT_DEL, 8'd0, '0);
    add_op(ACT_DEL, 8'd0, '0);
    add_op(ACT_DEL, 8'd0, '0);

    // random part: bursts that lean toward filling, draining or mixing
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(15, 50);
      end
      mode_left--;
      r = $urandom_range(0, 99);
      case (mode)
        0:       act = (r < 60) ? ACT_INS : (r < 75) ? ACT_DEL : (r < 96) ? ACT_READ : ACT_UNUSED;
        1:       act = (r < 15) ? ACT_INS : (r < 75) ? ACT_DEL : (r < 96) ? ACT_READ : ACT_UNUSED;
        default: act = (r < 35) ? ACT_INS : (r < 65) ? ACT_DEL : (r < 96) ? ACT_READ : ACT_UNUSED;
      endcase
      r = $urandom_range(0, 99);
      if (r < 70) pos = POS_W'($urandom_range(0, gen_len));
      else if (r < 80) pos = 8'd0;
      else if (r < 90) pos = 8'd255;
      else pos = POS_W'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 8) val = 32'hFFFF_FFFF;
      else if (r < 16) val = '0;
      else val = $urandom;
      add_op(act, pos, val);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || expected_views.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);

    $display("applied %0d items and checked %0d results over %0d cycles",
             accepted_ops, results_checked, cycles);
    $display("inserts refused at capacity: %0d, deletes/reads refused: %0d",
             full_rejects, empty_rejects);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
